FILE: rtl/core/ftl_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Shared types and codes for the flow table with least-recent eviction.
// ----------------------------------------------------------------------------
package ftl_pkg;

    localparam int KEY_W = 104;

    // Item kinds.
    localparam logic [2:0] KIND_PACKET    = 3'd0;
    localparam logic [2:0] KIND_CLASSIFY  = 3'd1;
    localparam logic [2:0] KIND_BLOCK     = 3'd2;
    localparam logic [2:0] KIND_TERMINATE = 3'd3;
    localparam logic [2:0] KIND_SWEEP     = 3'd4;
    localparam logic [2:0] KIND_CLEAR     = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_MISS    = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // Flow phases.
    localparam logic [2:0] PH_INITIATED  = 3'd0;
    localparam logic [2:0] PH_HANDSHAKE  = 3'd1;
    localparam logic [2:0] PH_ACTIVE     = 3'd2;
    localparam logic [2:0] PH_CLASSIFIED = 3'd3;
    localparam logic [2:0] PH_TERMINATED = 3'd4;

    // Packets seen before a handshaking flow counts as active.
    localparam logic [32:0] ACTIVE_PACKETS = 33'd3;

    // Per-entry state apart from the key and the time stamps.
    typedef struct packed {
        logic [2:0]  phase;
        logic        verdict;
        logic [7:0]  app;
        logic [31:0] pkts_rx;
        logic [31:0] pkts_tx;
        logic [47:0] octets_rx;
        logic [47:0] octets_tx;
    } t_entry;

endpackage

FILE: rtl/core/ftl_update.sv
// ----------------------------------------------------------------------------
// Flow table packet update
// Counts one packet into an entry and advances its phase.
// ----------------------------------------------------------------------------
module ftl_update (
    input  ftl_pkg::t_entry i_entry,
    input  logic            i_new,
    input  logic [15:0]     i_byte_count,
    input  logic            i_outbound,
    input  logic            i_syn_ack,
    output ftl_pkg::t_entry o_entry
);

    ftl_pkg::t_entry base;
    ftl_pkg::t_entry upd;
    logic [32:0]     pkt_sum;

    always_comb begin
        // A freshly created entry starts from all zero.
        base = i_new ? '0 : i_entry;
        upd  = base;
        if (i_outbound) begin
            upd.pkts_tx   = base.pkts_tx + 32'd1;
            upd.octets_tx = base.octets_tx + {32'd0, i_byte_count};
        end else begin
            upd.pkts_rx   = base.pkts_rx + 32'd1;
            upd.octets_rx = base.octets_rx + {32'd0, i_byte_count};
        end
        pkt_sum = {1'b0, upd.pkts_rx} + {1'b0, upd.pkts_tx};
        if (upd.phase == ftl_pkg::PH_INITIATED && i_syn_ack) begin
            upd.phase = ftl_pkg::PH_HANDSHAKE;
        end
        if (upd.phase == ftl_pkg::PH_HANDSHAKE && pkt_sum >= ftl_pkg::ACTIVE_PACKETS) begin
            upd.phase = ftl_pkg::PH_ACTIVE;
        end
        o_entry = upd;
    end

endmodule

FILE: rtl/core/flow_table_lru_stale_evict_top.sv
// ----------------------------------------------------------------------------
// Flow table with least-recent eviction and stale sweep
// Five-tuple flow table held in two synchronous memories.
// ----------------------------------------------------------------------------
// Each input beat is one item and yields exactly one result beat. The table
// keeps keys in one memory and per-flow data plus time stamps in another, both
// with a registered read; entry valid bits live in flip-flops and are cleared
// by reset, so no clearing pass is needed. Packet, classify, block, terminate
// and sweep items all walk the whole table once, one entry per cycle through
// the memory read port. A packet item, or a command item that finds its flow,
// goes from taking its input beat through the walk, then decide, read, modify
// and finish, before the next input beat is taken. A sweep or a command that
// misses skips the read and modify; a clear or an unknown kind goes from
// taking the beat straight to finish. A stalled output holds the block in
// finish. The walk finds the matching key, the lowest free slot and the least
// recently seen entry in one pass, after which the chosen slot is read,
// modified and written back. One item is in work at a time; a finished result
// waits in an output register while the block takes the next input beat.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module flow_table_lru_stale_evict_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Item input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_byte_count,
    input  logic        i_outbound,
    input  logic        i_syn_ack,
    input  logic [7:0]  i_app_code,
    input  logic [31:0] i_time_now,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [2:0]  o_phase,
    output logic        o_verdict,
    output logic        o_evicted,
    output logic [6:0]  o_removed_count,
    output logic [6:0]  o_occupied,
    output logic [31:0] o_total_created,
    output logic [31:0] o_classified_total,
    output logic [31:0] o_blocked_total
);

    localparam int SW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int EW     = $bits(ftl_pkg::t_entry);
    localparam int DW     = EW + 2 * TIME_BITS;
    localparam int KW     = ftl_pkg::KEY_W;
    localparam logic [SW-1:0] LAST = SW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_MOD    = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    // Configuration registers.
    logic [6:0]  r_capacity;
    logic [31:0] r_timeout;

    // Control state.
    logic [2:0]         r_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_created;
    logic [31:0]        r_classified;
    logic [31:0]        r_blocked;

    // Latched item.
    logic [2:0]         r_kind;
    logic [KW-1:0]      r_key;
    logic [15:0]        r_bytes;
    logic               r_outbound;
    logic               r_syn_ack;
    logic [7:0]         r_app;
    logic [TIME_BITS-1:0] r_now;

    // Table walk.
    logic [SW-1:0]      r_addr;
    logic               r_issue_done;
    logic               r_cvld;
    logic [SW-1:0]      r_cidx;
    logic               r_hit;
    logic [SW-1:0]      r_hit_idx;
    logic               r_free_fnd;
    logic [SW-1:0]      r_free_idx;
    logic               r_lru_fnd;
    logic [SW-1:0]      r_lru_idx;
    logic [TIME_BITS-1:0] r_lru_age;
    logic [CW-1:0]      r_removed;

    // Item result under construction.
    logic [SW-1:0]      r_slot;
    logic               r_new;
    logic [1:0]         r_res_status;
    logic [2:0]         r_res_phase;
    logic               r_res_verdict;
    logic               r_res_evicted;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic [5:0]         r_o_slot;
    logic [2:0]         r_o_phase;
    logic               r_o_verdict;
    logic               r_o_evicted;
    logic [6:0]         r_o_removed;
    logic [6:0]         r_o_occupied;
    logic [31:0]        r_o_created;
    logic [31:0]        r_o_classified;
    logic [31:0]        r_o_blocked;

    // Memories.
    logic [KW-1:0] key_mem  [TABLE_DEPTH];
    logic [DW-1:0] data_mem [TABLE_DEPTH];
    logic [KW-1:0] r_rd_key;
    logic [DW-1:0] r_rd_data;
    logic [SW-1:0] mem_addr;
    logic          key_we;
    logic          data_we;
    logic [DW-1:0] data_wr;

    // Combinational helpers.
    logic [KW-1:0]        in_key;
    logic [TIME_BITS+31:0] now_ext;
    logic                 in_fire;
    logic                 out_free;
    ftl_pkg::t_entry      rd_entry;
    logic [TIME_BITS-1:0] rd_last;
    logic [TIME_BITS-1:0] rd_first;
    logic [TIME_BITS-1:0] cmp_age;
    logic                 cmp_valid;
    logic                 stale;
    ftl_pkg::t_entry      pkt_entry;
    ftl_pkg::t_entry      cmd_entry;
    logic [CW+6:0]        cap_eff;
    logic                 table_full;
    logic [SW-1:0]        new_slot;
    logic [SW+5:0]        slot_ext;
    logic [CW+6:0]        occ_ext;
    logic [CW+6:0]        rem_ext;

    assign in_key   = {i_src_addr, i_dst_addr, i_src_port, i_dst_port, i_protocol};
    assign now_ext  = {TIME_BITS'(0), i_time_now};
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    assign rd_entry = ftl_pkg::t_entry'(r_rd_data[DW-1 -: EW]);
    assign rd_last  = r_rd_data[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_first = r_rd_data[TIME_BITS-1:0];

    // Age of the entry presented by the memory during the walk.
    assign cmp_age   = r_now - rd_last;
    assign cmp_valid = r_cvld && r_valid[r_cidx];
    assign stale     = {32'd0, cmp_age} > {TIME_BITS'(0), r_timeout};

    ftl_update u_update (
        .i_entry      (rd_entry),
        .i_new        (r_new),
        .i_byte_count (r_bytes),
        .i_outbound   (r_outbound),
        .i_syn_ack    (r_syn_ack),
        .o_entry      (pkt_entry)
    );

    always_comb begin
        cmd_entry = rd_entry;
        case (r_kind)
            ftl_pkg::KIND_CLASSIFY: begin
                cmd_entry.app   = r_app;
                cmd_entry.phase = ftl_pkg::PH_CLASSIFIED;
            end
            ftl_pkg::KIND_BLOCK: begin
                cmd_entry.verdict = 1'b1;
            end
            ftl_pkg::KIND_TERMINATE: begin
                cmd_entry.phase = ftl_pkg::PH_TERMINATED;
            end
            default: begin
                cmd_entry = rd_entry;
            end
        endcase
    end

    // Capacity clamped to the range one to the table depth.
    always_comb begin
        cap_eff = {CW'(0), r_capacity};
        if (r_capacity == 7'd0) begin
            cap_eff = (CW + 7)'(1);
        end else if (cap_eff > (CW + 7)'(TABLE_DEPTH)) begin
            cap_eff = (CW + 7)'(TABLE_DEPTH);
        end
    end

    assign table_full = {7'd0, r_count} >= cap_eff;

    // After an eviction the lowest free slot is the lower of the first free
    // slot seen in the walk and the evicted one.
    always_comb begin
        if (table_full) begin
            new_slot = (r_free_fnd && r_free_idx < r_lru_idx) ? r_free_idx : r_lru_idx;
        end else begin
            new_slot = r_free_idx;
        end
    end

    assign mem_addr = (r_state == S_RD) ? r_slot : r_addr;
    assign key_we   = (r_state == S_MOD) && r_new;
    assign data_we  = (r_state == S_MOD) && (r_hit || r_new);
    assign data_wr  = (r_kind == ftl_pkg::KIND_PACKET)
                    ? {pkt_entry, r_now, (r_new ? r_now : rd_first)}
                    : {cmd_entry, rd_last, rd_first};

    always_ff @(posedge i_clk) begin
        r_rd_key  <= key_mem[mem_addr];
        r_rd_data <= data_mem[mem_addr];
        if (key_we) begin
            key_mem[r_slot] <= r_key;
        end
        if (data_we) begin
            data_mem[r_slot] <= data_wr;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 7'd64;
            r_timeout  <= 32'd300;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) begin
                r_capacity <= i_cfg_data[6:0];
            end else begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Item payload; needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind     <= i_kind;
            r_key      <= in_key;
            r_bytes    <= i_byte_count;
            r_outbound <= i_outbound;
            r_syn_ack  <= i_syn_ack;
            r_app      <= i_app_code;
            r_now      <= now_ext[TIME_BITS-1:0];
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_count       <= '0;
            r_created     <= '0;
            r_classified  <= '0;
            r_blocked     <= '0;
            r_addr        <= '0;
            r_issue_done  <= 1'b0;
            r_cvld        <= 1'b0;
            r_cidx        <= '0;
            r_hit         <= 1'b0;
            r_hit_idx     <= '0;
            r_free_fnd    <= 1'b0;
            r_free_idx    <= '0;
            r_lru_fnd     <= 1'b0;
            r_lru_idx     <= '0;
            r_lru_age     <= '0;
            r_removed     <= '0;
            r_slot        <= '0;
            r_new         <= 1'b0;
            r_res_status  <= ftl_pkg::ST_MISS;
            r_res_phase   <= ftl_pkg::PH_INITIATED;
            r_res_verdict <= 1'b0;
            r_res_evicted <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_addr        <= '0;
                        r_issue_done  <= 1'b0;
                        r_cvld        <= 1'b0;
                        r_hit         <= 1'b0;
                        r_free_fnd    <= 1'b0;
                        r_lru_fnd     <= 1'b0;
                        r_removed     <= '0;
                        r_new         <= 1'b0;
                        r_slot        <= '0;
                        r_res_phase   <= ftl_pkg::PH_INITIATED;
                        r_res_verdict <= 1'b0;
                        r_res_evicted <= 1'b0;
                        if (i_kind <= ftl_pkg::KIND_SWEEP) begin
                            r_state <= S_SCAN;
                        end else if (i_kind == ftl_pkg::KIND_CLEAR) begin
                            r_valid      <= '0;
                            r_count      <= '0;
                            r_created    <= '0;
                            r_classified <= '0;
                            r_blocked    <= '0;
                            r_res_status <= ftl_pkg::ST_DONE;
                            r_state      <= S_FIN;
                        end else begin
                            r_res_status <= ftl_pkg::ST_MISS;
                            r_state      <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle; compare in the cycle after each read is issued.
                    if (!r_issue_done) begin
                        r_cvld <= 1'b1;
                        r_cidx <= r_addr;
                        if (r_addr == LAST) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + SW'(1);
                        end
                    end else begin
                        r_cvld <= 1'b0;
                    end
                    if (r_cvld) begin
                        if (!r_valid[r_cidx] && !r_free_fnd) begin
                            r_free_fnd <= 1'b1;
                            r_free_idx <= r_cidx;
                        end
                        if (cmp_valid && r_rd_key == r_key) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_cidx;
                        end
                        if (cmp_valid && (!r_lru_fnd || cmp_age > r_lru_age)) begin
                            r_lru_fnd <= 1'b1;
                            r_lru_idx <= r_cidx;
                            r_lru_age <= cmp_age;
                        end
                        if (r_kind == ftl_pkg::KIND_SWEEP && cmp_valid && stale) begin
                            r_valid[r_cidx] <= 1'b0;
                            r_count         <= r_count - CW'(1);
                            r_removed       <= r_removed + CW'(1);
                        end
                        if (r_cidx == LAST) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_kind == ftl_pkg::KIND_SWEEP) begin
                        r_res_status <= ftl_pkg::ST_DONE;
                        r_state      <= S_FIN;
                    end else if (r_hit) begin
                        r_slot       <= r_hit_idx;
                        r_res_status <= ftl_pkg::ST_HIT;
                        r_state      <= S_RD;
                    end else if (r_kind == ftl_pkg::KIND_PACKET) begin
                        if (table_full) begin
                            r_valid[r_lru_idx] <= 1'b0;
                            r_count            <= r_count - CW'(1);
                            r_res_evicted      <= 1'b1;
                        end
                        r_slot       <= new_slot;
                        r_new        <= 1'b1;
                        r_res_status <= ftl_pkg::ST_CREATED;
                        r_state      <= S_RD;
                    end else begin
                        r_res_status <= ftl_pkg::ST_MISS;
                        r_state      <= S_FIN;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_kind == ftl_pkg::KIND_PACKET) begin
                        r_res_phase   <= pkt_entry.phase;
                        r_res_verdict <= pkt_entry.verdict;
                        if (r_new) begin
                            r_valid[r_slot] <= 1'b1;
                            r_count         <= r_count + CW'(1);
                            r_created       <= r_created + 32'd1;
                        end
                    end else begin
                        r_res_phase   <= cmd_entry.phase;
                        r_res_verdict <= cmd_entry.verdict;
                        if (r_kind == ftl_pkg::KIND_CLASSIFY) begin
                            r_classified <= r_classified + 32'd1;
                        end
                        if (r_kind == ftl_pkg::KIND_BLOCK) begin
                            r_blocked <= r_blocked + 32'd1;
                        end
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign slot_ext = {6'd0, r_slot};
    assign occ_ext  = {7'd0, r_count};
    assign rem_ext  = {7'd0, r_removed};

    // Output register: loaded when a result is finished and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_status <= r_res_status;
            if (r_res_status == ftl_pkg::ST_HIT || r_res_status == ftl_pkg::ST_CREATED) begin
                r_o_slot    <= slot_ext[5:0];
                r_o_phase   <= r_res_phase;
                r_o_verdict <= r_res_verdict;
            end else begin
                r_o_slot    <= 6'd0;
                r_o_phase   <= ftl_pkg::PH_INITIATED;
                r_o_verdict <= 1'b0;
            end
            r_o_evicted    <= r_res_evicted;
            r_o_removed    <= rem_ext[6:0];
            r_o_occupied   <= occ_ext[6:0];
            r_o_created    <= r_created;
            r_o_classified <= r_classified;
            r_o_blocked    <= r_blocked;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_slot             = r_o_slot;
    assign o_phase            = r_o_phase;
    assign o_verdict          = r_o_verdict;
    assign o_evicted          = r_o_evicted;
    assign o_removed_count    = r_o_removed;
    assign o_occupied         = r_o_occupied;
    assign o_total_created    = r_o_created;
    assign o_classified_total = r_o_classified;
    assign o_blocked_total    = r_o_blocked;

endmodule
